// File: src/bts_pkg.sv
// Shared types, widths and helpers for the bilinear texture sampler
package bts_pkg;

  // Texture geometry
  localparam int MAX_SIDE        = 256;
  localparam int SIDE_W          = $clog2(MAX_SIDE) + 1;   // side register width
  localparam int CELL_W          = $clog2(MAX_SIDE);       // cell index width
  localparam int TEXEL_DEPTH     = 65536;
  localparam int ADDR_W          = $clog2(TEXEL_DEPTH);
  localparam int CHAN_W          = 8;
  localparam int NUM_CHAN        = 3;
  localparam int TEXEL_W         = NUM_CHAN * CHAN_W;

  // Fixed point
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = COORD_FRAC_BITS + 2;    // signed Q1.F input
  localparam int ONE_W           = COORD_FRAC_BITS + 1;    // clamped coordinate 0..ONE
  localparam int POS_W           = ONE_W + CELL_W;         // coordinate times (side-1)
  localparam int WEIGHT_W        = 2 * COORD_FRAC_BITS + 1;
  localparam int ACC_W           = 2 * COORD_FRAC_BITS + CHAN_W;
  localparam int RES_W           = 16;
  localparam int CORNER_W        = 2;

  localparam logic [ONE_W-1:0] COORD_ONE = {1'b1, {COORD_FRAC_BITS{1'b0}}};

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Item kinds
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_ROW,
    S_FETCH,
    S_DRAIN1,
    S_DRAIN2,
    S_DONE
  } state_t;

  // Coordinate unit controls
  typedef struct packed {
    logic capture;
    logic scale;
    logic row;
  } coord_ctrl_t;

  // Split coordinates and row bases for the four corners
  typedef struct packed {
    logic [CELL_W-1:0]          x0;
    logic [CELL_W-1:0]          x1;
    logic [COORD_FRAC_BITS-1:0] s;
    logic [COORD_FRAC_BITS-1:0] t;
    logic [ADDR_W-1:0]          base0;
    logic [ADDR_W-1:0]          base1;
  } coord_info_t;

  // Channel lane controls
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } lane_ctrl_t;

  // Side clamped to 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] raw);
    logic [SIDE_W-1:0] r;
    if (raw == '0) r = SIDE_W'(1);
    else if (raw > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    else r = raw;
    return r;
  endfunction

  // Clamped side minus one, fits the cell width
  function automatic logic [CELL_W-1:0] side_m1(input logic [SIDE_W-1:0] raw);
    logic [SIDE_W-1:0] c;
    logic [SIDE_W-1:0] m;
    c = side_clamp(raw);
    m = c - SIDE_W'(1);
    return m[CELL_W-1:0];
  endfunction

  // Signed Q1.F coordinate clamped to 0..ONE
  function automatic logic [ONE_W-1:0] coord_clamp(input logic [COORD_W-1:0] raw);
    logic [ONE_W-1:0] r;
    if (raw[COORD_W-1]) r = '0;
    else if (raw[COORD_W-2:0] > COORD_ONE) r = COORD_ONE;
    else r = raw[ONE_W-1:0];
    return r;
  endfunction

endpackage

// File: src/bts_if.sv
// Request channel: load or sample items
interface bts_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [bts_pkg::ADDR_W-1:0]           texel_index;
  logic [bts_pkg::CHAN_W-1:0]           load_red;
  logic [bts_pkg::CHAN_W-1:0]           load_green;
  logic [bts_pkg::CHAN_W-1:0]           load_blue;
  logic signed [bts_pkg::COORD_W-1:0]   u_coord;
  logic signed [bts_pkg::COORD_W-1:0]   v_coord;

  modport source (output valid, req_type, texel_index, load_red, load_green, load_blue,
                  u_coord, v_coord, input ready);
  modport sink   (input valid, req_type, texel_index, load_red, load_green, load_blue,
                  u_coord, v_coord, output ready);
endinterface

// Response channel: one filtered color per sample item
interface bts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bts_pkg::RES_W-1:0]     red;
  logic [bts_pkg::RES_W-1:0]     green;
  logic [bts_pkg::RES_W-1:0]     blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: src/bts_texel_ram.sv
// Single-port texel memory, read-first, registered read data
module bts_texel_ram #(
  parameter int DATA_W = 24,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/bts_coord.sv
// Coordinate unit: clamp, scale by side-1, split into cell and fraction,
// and form the two row base addresses.
module bts_coord (
  input  logic                             clk,
  input  bts_pkg::coord_ctrl_t             ctrl,
  input  logic [bts_pkg::COORD_W-1:0]      u_coord,
  input  logic [bts_pkg::COORD_W-1:0]      v_coord,
  input  logic [bts_pkg::SIDE_W-1:0]       texture_width,
  input  logic [bts_pkg::SIDE_W-1:0]       texture_height,
  output bts_pkg::coord_info_t             info
);

  logic [bts_pkg::ONE_W-1:0]           cu;
  logic [bts_pkg::ONE_W-1:0]           cv;
  logic [bts_pkg::POS_W-1:0]           px;
  logic [bts_pkg::POS_W-1:0]           py;
  logic [bts_pkg::SIDE_W-1:0]          wcl;
  logic [bts_pkg::CELL_W-1:0]          x0_n;
  logic [bts_pkg::CELL_W-1:0]          y0_n;
  logic [bts_pkg::CELL_W-1:0]          y1_n;
  logic [bts_pkg::COORD_FRAC_BITS-1:0] s_n;
  logic [bts_pkg::COORD_FRAC_BITS-1:0] t_n;
  logic [bts_pkg::CELL_W+bts_pkg::SIDE_W-1:0] row0_prod;
  logic [bts_pkg::CELL_W+bts_pkg::SIDE_W-1:0] row1_prod;

  assign wcl  = bts_pkg::side_clamp(texture_width);
  assign x0_n = px[bts_pkg::COORD_FRAC_BITS +: bts_pkg::CELL_W];
  assign y0_n = py[bts_pkg::COORD_FRAC_BITS +: bts_pkg::CELL_W];
  assign s_n  = px[bts_pkg::COORD_FRAC_BITS-1:0];
  assign t_n  = py[bts_pkg::COORD_FRAC_BITS-1:0];
  // far row only steps when the fraction is nonzero
  assign y1_n = y0_n + bts_pkg::CELL_W'(t_n != '0);
  assign row0_prod = {{bts_pkg::SIDE_W{1'b0}}, y0_n} * {{bts_pkg::CELL_W{1'b0}}, wcl};
  assign row1_prod = {{bts_pkg::SIDE_W{1'b0}}, y1_n} * {{bts_pkg::CELL_W{1'b0}}, wcl};

  // clamp stage
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cu <= bts_pkg::coord_clamp(u_coord);
      cv <= bts_pkg::coord_clamp(v_coord);
    end
  end

  // scale stage
  always_ff @(posedge clk) begin
    if (ctrl.scale) begin
      px <= bts_pkg::POS_W'(cu) * bts_pkg::POS_W'(bts_pkg::side_m1(texture_width));
      py <= bts_pkg::POS_W'(cv) * bts_pkg::POS_W'(bts_pkg::side_m1(texture_height));
    end
  end

  // split stage, row bases wrap modulo the store depth
  always_ff @(posedge clk) begin
    if (ctrl.row) begin
      info.x0    <= x0_n;
      info.x1    <= x0_n + bts_pkg::CELL_W'(s_n != '0);
      info.s     <= s_n;
      info.t     <= t_n;
      info.base0 <= row0_prod[bts_pkg::ADDR_W-1:0];
      info.base1 <= row1_prod[bts_pkg::ADDR_W-1:0];
    end
  end

endmodule

// File: src/bts_lane.sv
// One color channel: texel byte times corner weight, accumulated over corners
module bts_lane (
  input  logic                          clk,
  input  bts_pkg::lane_ctrl_t           ctrl,
  input  logic [bts_pkg::CHAN_W-1:0]    texel,
  input  logic [bts_pkg::WEIGHT_W-1:0]  weight,
  output logic [bts_pkg::RES_W-1:0]     result
);

  logic [bts_pkg::CHAN_W+bts_pkg::WEIGHT_W-1:0] prod_full;
  logic [bts_pkg::ACC_W-1:0]                    prod;
  logic [bts_pkg::ACC_W-1:0]                    acc;

  assign prod_full = {{bts_pkg::WEIGHT_W{1'b0}}, texel} * {{bts_pkg::CHAN_W{1'b0}}, weight};

  // product register; the value never exceeds 255 * ONE^2
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= prod_full[bts_pkg::ACC_W-1:0];
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + prod;
    end
  end

  // Q8.8 result, truncated
  assign result = acc[bts_pkg::ACC_W-1 -: bts_pkg::RES_W];

endmodule

// File: src/bilinear_texture_sampler_unit.sv
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   req_type, texel_index, load_red/green/blue, u_coord, v_coord
// rsp      out  valid/ready   red, green, blue (Q8.8)
// apb      in   psel/penable  paddr, pwdata, prdata; registers texture_width, texture_height
//
// A load item writes the texel at the accepting edge.
// A sample item steps through clamp, scale, split, four corner reads on the
// single memory port, the lane product and accumulate registers, and the output merge.
// rst is synchronous; it clears control state and sets both sides to 256.
// A finished result waits in the output register; loads keep flowing meanwhile, and
// a following sample stalls only in its final merge cycle until rsp takes the result.
module bilinear_texture_sampler_unit (
  input  logic                               clk,
  input  logic                               rst,
  bts_req_if.sink                            req,
  bts_rsp_if.source                          rsp,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bts_pkg::PADDR_W-1:0]        paddr,
  input  logic [bts_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bts_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  bts_pkg::state_t                     state;
  bts_pkg::state_t                     state_next;
  logic [bts_pkg::SIDE_W-1:0]          texture_width;
  logic [bts_pkg::SIDE_W-1:0]          texture_height;
  logic                                reg_idx;
  logic                                cfg_we;
  logic                                req_fire;
  logic                                done_fire;
  logic                                ram_we;
  logic [bts_pkg::ADDR_W-1:0]          ram_addr;
  logic [bts_pkg::ADDR_W-1:0]          fetch_addr;
  logic [bts_pkg::TEXEL_W-1:0]         ram_wdata;
  logic [bts_pkg::TEXEL_W-1:0]         ram_rdata;
  logic [bts_pkg::CORNER_W-1:0]        corner;
  logic                                fetch_vld;
  logic                                mul_vld;
  logic [bts_pkg::ONE_W-1:0]           wx;
  logic [bts_pkg::ONE_W-1:0]           wy;
  logic [2*bts_pkg::ONE_W-1:0]         wprod;
  logic [bts_pkg::WEIGHT_W-1:0]        weight;
  logic                                out_valid;
  logic [bts_pkg::RES_W-1:0]           lane_res [bts_pkg::NUM_CHAN];
  bts_pkg::coord_ctrl_t                coord_ctrl;
  bts_pkg::coord_info_t                cinfo;
  bts_pkg::lane_ctrl_t                 lane_ctrl;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[bts_pkg::PADDR_W-1];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width  <= bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE);
      texture_height <= bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE);
    end else if (cfg_we) begin
      unique case (reg_idx)
        bts_pkg::REG_WIDTH:  texture_width  <= pwdata[bts_pkg::SIDE_W-1:0];
        bts_pkg::REG_HEIGHT: texture_height <= pwdata[bts_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bts_pkg::REG_WIDTH:  prdata = bts_pkg::APB_DATA_W'(texture_width);
      bts_pkg::REG_HEIGHT: prdata = bts_pkg::APB_DATA_W'(texture_height);
      default:             prdata = '0;
    endcase
  end

  // handshakes
  assign req.ready = (state == bts_pkg::S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign done_fire = (state == bts_pkg::S_DONE) && (!out_valid || rsp.ready);

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      bts_pkg::S_IDLE:
        if (req_fire && req.req_type == bts_pkg::REQ_SAMPLE) state_next = bts_pkg::S_SCALE;
      bts_pkg::S_SCALE:  state_next = bts_pkg::S_ROW;
      bts_pkg::S_ROW:    state_next = bts_pkg::S_FETCH;
      bts_pkg::S_FETCH:
        if (corner == '1) state_next = bts_pkg::S_DRAIN1;
      bts_pkg::S_DRAIN1: state_next = bts_pkg::S_DRAIN2;
      bts_pkg::S_DRAIN2: state_next = bts_pkg::S_DONE;
      bts_pkg::S_DONE:
        if (done_fire) state_next = bts_pkg::S_IDLE;
      default:           state_next = bts_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    coord_ctrl.capture = req_fire && (req.req_type == bts_pkg::REQ_SAMPLE);
    coord_ctrl.scale   = (state == bts_pkg::S_SCALE);
    coord_ctrl.row     = (state == bts_pkg::S_ROW);
    lane_ctrl.clear    = (state == bts_pkg::S_ROW);
    lane_ctrl.mul_en   = fetch_vld;
    lane_ctrl.acc_en   = mul_vld;
    ram_we             = req_fire && (req.req_type == bts_pkg::REQ_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bts_pkg::S_IDLE;
      corner    <= '0;
      fetch_vld <= 1'b0;
      mul_vld   <= 1'b0;
    end else begin
      state     <= state_next;
      fetch_vld <= (state == bts_pkg::S_FETCH);
      mul_vld   <= fetch_vld;
      if (state == bts_pkg::S_ROW) corner <= '0;
      else if (state == bts_pkg::S_FETCH) corner <= corner + bts_pkg::CORNER_W'(1);
    end
  end

  bts_coord u_coord (
    .clk            (clk),
    .ctrl           (coord_ctrl),
    .u_coord        (req.u_coord),
    .v_coord        (req.v_coord),
    .texture_width  (texture_width),
    .texture_height (texture_height),
    .info           (cinfo)
  );

  // corner address and weight; corner bit 0 picks the far column, bit 1 the far row
  assign fetch_addr = (corner[1] ? cinfo.base1 : cinfo.base0)
                    + bts_pkg::ADDR_W'(corner[0] ? cinfo.x1 : cinfo.x0);
  assign wx    = corner[0] ? {1'b0, cinfo.s} : bts_pkg::COORD_ONE - {1'b0, cinfo.s};
  assign wy    = corner[1] ? {1'b0, cinfo.t} : bts_pkg::COORD_ONE - {1'b0, cinfo.t};
  assign wprod = {{bts_pkg::ONE_W{1'b0}}, wx} * {{bts_pkg::ONE_W{1'b0}}, wy};

  always_ff @(posedge clk) begin
    if (state == bts_pkg::S_FETCH) begin
      weight <= wprod[bts_pkg::WEIGHT_W-1:0];
    end
  end

  // single memory port: load write while idle, corner reads otherwise
  assign ram_addr  = (state == bts_pkg::S_IDLE) ? req.texel_index : fetch_addr;
  assign ram_wdata = {req.load_red, req.load_green, req.load_blue};

  bts_texel_ram #(
    .DATA_W (bts_pkg::TEXEL_W),
    .ADDR_W (bts_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // channel lanes, red in the top byte
  for (genvar i = 0; i < bts_pkg::NUM_CHAN; i++) begin : g_lane
    bts_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .texel  (ram_rdata[(bts_pkg::NUM_CHAN-1-i)*bts_pkg::CHAN_W +: bts_pkg::CHAN_W]),
      .weight (weight),
      .result (lane_res[i])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      rsp.red   <= lane_res[0];
      rsp.green <= lane_res[1];
      rsp.blue  <= lane_res[2];
    end
  end

  assign rsp.valid = out_valid;

  // checks
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.req_type == bts_pkg::REQ_LOAD |=> state == bts_pkg::S_IDLE)
    else $error("load item left the idle state");

  a_four_corners: assert property (@(posedge clk) disable iff (rst)
    state == bts_pkg::S_FETCH && corner == '1 |=> state == bts_pkg::S_DRAIN1)
    else $error("fetch did not end after four corners");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bts_pkg::S_DONE)
    else $error("result raised outside the merge cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |-> !done_fire)
    else $error("pending result overwritten");

  a_acc_after_clear: assert property (@(posedge clk) disable iff (rst)
    lane_ctrl.acc_en |-> !lane_ctrl.clear && state != bts_pkg::S_IDLE)
    else $error("lane accumulate outside a sample");

endmodule
